// ===== sv/positional_list_engine_defines.svh =====
// Assertion macros used by the positional list engine top level.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ple_pkg.sv =====
// Shared types and constants of the positional list engine.
package ple_pkg;

	localparam int PLE_CAPACITY = 64;

	localparam int OP_W    = 2;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 8;
	localparam int ST_W    = 2;
	localparam int CNTO_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} ple_op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} ple_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PLACE,
		S_READ,
		S_READ_WAIT,
		S_RESP
	} ple_state_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic up;
	} ple_step_ctrl_t;

	typedef struct packed {
		logic last;
	} ple_step_stat_t;

endpackage

// ===== sv/ple_cmd_if.sv =====
// Command channel: valid/ready with operation, position and value.
interface ple_cmd_if import ple_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] item_value;

	modport source (output valid, operation, position, item_value, input ready);
	modport sink (input valid, operation, position, item_value, output ready);
endinterface

// ===== sv/ple_rsp_if.sv =====
// Response channel: valid/ready with read byte, status, count and empty flag.
interface ple_rsp_if import ple_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  read_value;
	logic [ST_W-1:0]   status;
	logic [CNTO_W-1:0] entry_count;
	logic              is_empty;

	modport source (output valid, read_value, status, entry_count, is_empty, input ready);
	modport sink (input valid, read_value, status, entry_count, is_empty, output ready);
endinterface

// ===== sv/positional_list_engine.sv =====
// Top level of the positional list engine: sequencer, count and result registers.
//
// Ordered list of up to CAPACITY bytes addressed by 1-based position. One
// command beat (insert, delete or read) is taken while the engine is idle and
// answered by exactly one response beat carrying the byte read, a status, the
// entry count after the command and an empty flag. The list lives in a RAM
// with one write and one registered read port; entries are moved one at a
// time by a shared index unit, each move being a read step followed by a
// write step. A rejected or unused command goes from decode straight to the
// response; a read passes a RAM read and a wait; an insert moves its entries
// and then writes the new byte; a delete moves its entries. The number of
// entries that move is count - position + 1 for an insert and count -
// position for a delete, at most CAPACITY-1. After the response beat the
// engine returns to idle before it takes the next command beat.
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = PLE_CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	ple_cmd_if.sink   cmd,
	ple_rsp_if.source rsp
);
`include "positional_list_engine_defines.svh"

	localparam int AW   = $clog2(CAPACITY);
	localparam int CNTW = $clog2(CAPACITY + 1);
	// compare width: holds position, count and count+1 without overflow
	localparam int PW   = ((CNTW > POS_W) ? CNTW : POS_W) + 1;

	ple_state_t       state_q, state_d;
	ple_op_t          op_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [CNTW-1:0]  count_q;
	ple_status_t      status_q;
	logic [VAL_W-1:0] rdval_q;

	// decode helpers
	logic [PW-1:0] pos_x, cnt_x, pos_m1, cnt_m2;
	logic          ins_pos_ok, acc_pos_ok, is_full, list_empty;

	// sequencer outputs
	ple_step_ctrl_t step_ctrl;
	ple_step_stat_t step_stat;
	logic [AW-1:0]  start_idx, end_idx, src_addr, dst_addr;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [VAL_W-1:0] ram_wdata, ram_rdata;
	logic           cnt_inc, cnt_dec, res_ld, rd_ld;
	ple_status_t    res_status;

	assign pos_x      = PW'(pos_q);
	assign cnt_x      = PW'(count_q);
	assign pos_m1     = pos_x - PW'(1);
	assign cnt_m2     = cnt_x - PW'(2);
	assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));
	assign acc_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
	assign is_full    = (cnt_x == PW'(CAPACITY));
	assign list_empty = (count_q == '0);

	ple_step #(.AW(AW)) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (step_ctrl),
		.start_idx(start_idx),
		.end_idx  (end_idx),
		.src_addr (src_addr),
		.dst_addr (dst_addr),
		.stat     (step_stat)
	);

	ple_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		step_ctrl  = '0;
		start_idx  = '0;
		end_idx    = '0;
		ram_we     = 1'b0;
		ram_waddr  = dst_addr;
		ram_wdata  = ram_rdata;
		ram_raddr  = src_addr;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		res_ld     = 1'b0;
		res_status = ST_OK;
		rd_ld      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				res_ld = 1'b1;
				case (op_q)
					OP_INSERT: begin
						if (!ins_pos_ok) begin
							res_status = ST_RANGE;
							state_d    = S_RESP;
						end else if (is_full) begin
							res_status = ST_FULL;
							state_d    = S_RESP;
						end else if (pos_x == cnt_x + PW'(1)) begin
							// append: nothing moves
							state_d = S_PLACE;
						end else begin
							// move entries count-1 .. pos-1 up by one, top first
							step_ctrl.load = 1'b1;
							step_ctrl.up   = 1'b0;
							start_idx      = cnt_x[AW-1:0];
							end_idx        = pos_x[AW-1:0];
							state_d        = S_SHIFT_RD;
						end
					end
					OP_DELETE, OP_READ: begin
						if (list_empty) begin
							res_status = ST_EMPTY;
							state_d    = S_RESP;
						end else if (!acc_pos_ok) begin
							res_status = ST_RANGE;
							state_d    = S_RESP;
						end else if (op_q == OP_READ) begin
							state_d = S_READ;
						end else if (pos_x == cnt_x) begin
							// last entry: nothing moves
							cnt_dec = 1'b1;
							state_d = S_RESP;
						end else begin
							// move entries pos .. count-1 down by one, bottom first
							step_ctrl.load = 1'b1;
							step_ctrl.up   = 1'b1;
							start_idx      = pos_m1[AW-1:0];
							end_idx        = cnt_m2[AW-1:0];
							state_d        = S_SHIFT_RD;
						end
					end
					default: begin
						// unused code: ok, no change
						state_d = S_RESP;
					end
				endcase
			end
			S_SHIFT_RD: begin
				// read address is the source entry
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				ram_we = 1'b1;
				if (step_stat.last) begin
					if (op_q == OP_INSERT) begin
						state_d = S_PLACE;
					end else begin
						cnt_dec = 1'b1;
						state_d = S_RESP;
					end
				end else begin
					step_ctrl.advance = 1'b1;
					state_d           = S_SHIFT_RD;
				end
			end
			S_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = pos_m1[AW-1:0];
				ram_wdata = val_q;
				cnt_inc   = 1'b1;
				state_d   = S_RESP;
			end
			S_READ: begin
				ram_raddr = pos_m1[AW-1:0];
				state_d   = S_READ_WAIT;
			end
			S_READ_WAIT: begin
				rd_ld   = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// command capture
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q  <= ple_op_t'(cmd.operation);
			pos_q <= cmd.position;
			val_q <= cmd.item_value;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cnt_inc) begin
			count_q <= count_q + CNTW'(1);
		end else if (cnt_dec) begin
			count_q <= count_q - CNTW'(1);
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (res_ld) begin
			status_q <= res_status;
			rdval_q  <= '0;
		end else if (rd_ld) begin
			rdval_q <= ram_rdata;
		end
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = (state_q == S_RESP);
	assign rsp.read_value  = rdval_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = cnt_x[CNTO_W-1:0];
	assign rsp.is_empty    = list_empty;

	`PLE_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_x <= PW'(CAPACITY))
	`PLE_ASSERT_IMPL(a_one_side, clk, arst_n, 1'b1, !(cmd.ready && rsp.valid))
	`PLE_ASSERT_NEXT(a_accept_decode, clk, arst_n, cmd.valid && cmd.ready,
		state_q == S_DECODE)
	`PLE_ASSERT_NEXT(a_idle_cnt, clk, arst_n, state_q == S_IDLE, $stable(count_q))
endmodule

// ===== sv/ple_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module ple_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/ple_step.sv =====
// Shared index unit: walks the shift window one entry per step.
module ple_step import ple_pkg::*; #(
	parameter int AW = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ple_step_ctrl_t ctrl,
	input  logic [AW-1:0]  start_idx,
	input  logic [AW-1:0]  end_idx,
	output logic [AW-1:0]  src_addr,
	output logic [AW-1:0]  dst_addr,
	output ple_step_stat_t stat
);
	logic [AW-1:0] idx_q;
	logic [AW-1:0] end_q;
	logic          up_q;
	logic [AW-1:0] nb;

	// one incrementer/decrementer gives both the source and the next index
	assign nb       = up_q ? idx_q + AW'(1) : idx_q - AW'(1);
	assign src_addr = nb;
	assign dst_addr = idx_q;
	assign stat.last = (idx_q == end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			end_q <= '0;
			up_q  <= 1'b0;
		end else if (ctrl.load) begin
			idx_q <= start_idx;
			end_q <= end_idx;
			up_q  <= ctrl.up;
		end else if (ctrl.advance) begin
			idx_q <= nb;
		end
	end
endmodule

// ===== verif/positional_list_engine_tb.sv =====
// Self-checking testbench for the positional list engine.
module positional_list_engine_tb import ple_pkg::*; ();

	// Operation code 3 is not decoded by the engine; it must come back as a
	// plain OK reply with the list untouched.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_CMDS   = 830;   // decoded commands after the directed part
	localparam int PHASE_LEN     = 80;    // commands per insert-weight phase
	localparam int HOLD_CYCLES   = 250;   // long receiver hold-off
	localparam int DRAIN_CYCLES  = 200;   // beyond the longest insert
	localparam int WATCHDOG_MAX  = 5000;  // cycles with no beat on either side
	localparam int IDLE_PERCENT  = 22;

	// Mirror of the list: a queue holds the entries in list order, so insert
	// and delete at a position are single queue operations.
	class list_mirror;
		typedef struct packed {
			logic [VAL_W-1:0]  read_value;
			ple_status_t       status;
			logic [CNTO_W-1:0] entry_count;
			logic              is_empty;
		} list_reply_t;

		logic [VAL_W-1:0] entries[$];
		list_reply_t      replies_due[$];
		int unsigned      mismatches;
		int unsigned      replies_seen;
		int unsigned      commands_seen;
		int unsigned      unused_seen;
		int unsigned      peak_fill;
		int unsigned      status_tally[4];

		// Applies one accepted command beat and queues the reply it must cause.
		function void apply_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
				logic [VAL_W-1:0] val);
			list_reply_t r;
			int          n;
			int          p;
			n = entries.size();
			p = pos;
			r = '0;
			r.status = ST_OK;
			commands_seen++;
			case (op)
				OP_INSERT: begin
					if (p < 1 || p > n + 1)
						r.status = ST_RANGE;
					else if (n >= PLE_CAPACITY)
						r.status = ST_FULL;
					else
						entries.insert(p - 1, val);
				end
				OP_DELETE, OP_READ: begin
					if (n == 0)
						r.status = ST_EMPTY;
					else if (p < 1 || p > n)
						r.status = ST_RANGE;
					else if (op == OP_READ)
						r.read_value = entries[p - 1];
					else
						entries.delete(p - 1);
				end
				default: unused_seen++;
			endcase
			r.entry_count = CNTO_W'(entries.size());
			r.is_empty = (entries.size() == 0);
			if (entries.size() > peak_fill)
				peak_fill = entries.size();
			status_tally[r.status]++;
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [VAL_W-1:0] rv, logic [ST_W-1:0] st,
				logic [CNTO_W-1:0] cnt, logic emp);
			list_reply_t e;
			replies_seen++;
			if (replies_due.size() == 0) begin
				$error("reply beat with no command outstanding");
				mismatches++;
				return;
			end
			e = replies_due.pop_front();
			if (rv !== e.read_value) begin
				$error("read_value: expected %0d, got %0d", e.read_value, rv);
				mismatches++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				mismatches++;
			end
			if (cnt !== e.entry_count) begin
				$error("entry_count: expected %0d, got %0d", e.entry_count, cnt);
				mismatches++;
			end
			if (emp !== e.is_empty) begin
				$error("is_empty: expected %0d, got %0d", e.is_empty, emp);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;   // suppresses random idling on both sides

	ple_cmd_if cmd ();
	ple_rsp_if rsp ();

	list_mirror mirror = new();

	positional_list_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offers one command beat and returns at the edge that accepts it. The
	// mirror is updated right there, so the next command is chosen against
	// the list as the engine will hold it.
	task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.operation  <= op;
		cmd.position   <= pos;
		cmd.item_value <= val;
		do
			@(posedge clk);
		while (!cmd.ready);
		mirror.apply_command(op, pos, val);
	endtask

	// Mostly a legal position (1..hi); now and then anything the field holds,
	// which also reaches the top bits of the position.
	function automatic logic [POS_W-1:0] pick_position(int hi);
		if (hi >= 1 && $urandom_range(99) < 85)
			return POS_W'($urandom_range(hi, 1));
		return POS_W'($urandom_range(127, 0));
	endfunction

	// Directed opening: empty-list checks, range checks on both sides of the
	// legal window, head/middle/tail insert and delete, the unused code.
	task automatic run_directed();
		send_command(OP_READ,   7'd1,   8'h00);   // read on empty
		send_command(OP_DELETE, 7'd1,   8'h00);   // delete on empty
		send_command(OP_DELETE, 7'd127, 8'hFF);   // empty beats the range check
		send_command(OP_INSERT, 7'd0,   8'h33);   // position zero
		send_command(OP_INSERT, 7'd2,   8'h44);   // past count+1 on empty list
		send_command(OP_INSERT, 7'd1,   8'h00);
		send_command(OP_INSERT, 7'd2,   8'hFF);   // tail
		send_command(OP_INSERT, 7'd1,   8'hA5);   // head
		send_command(OP_INSERT, 7'd3,   8'h5A);   // middle: A5 00 5A FF
		send_command(OP_INSERT, 7'd127, 8'h11);
		send_command(OP_READ,   7'd1,   8'h00);
		send_command(OP_READ,   7'd2,   8'hFF);
		send_command(OP_READ,   7'd3,   8'h00);
		send_command(OP_READ,   7'd4,   8'h00);
		send_command(OP_READ,   7'd0,   8'h00);
		send_command(OP_READ,   7'd5,   8'h00);   // count+1 is illegal for read
		send_command(OP_READ,   7'd127, 8'h00);
		send_command(OP_DELETE, 7'd0,   8'h00);
		send_command(OP_DELETE, 7'd5,   8'h00);   // count+1 is illegal for delete
		send_command(OP_UNUSED, 7'd127, 8'hFF);
		send_command(OP_DELETE, 7'd2,   8'h00);   // middle
		send_command(OP_DELETE, 7'd3,   8'h00);   // tail
		send_command(OP_DELETE, 7'd1,   8'h00);   // head
		send_command(OP_DELETE, 7'd1,   8'h00);   // last entry out
		send_command(OP_READ,   7'd1,   8'h00);
	endtask

	// Random part in phases of fixed insert weight: heavy-insert phases push
	// the list to capacity (full status), light ones drain it to empty.
	task automatic run_random();
		int             weights[7] = '{95, 50, 10, 80, 30, 95, 5};
		int             done;
		int             n;
		logic [OP_W-1:0] op;
		done = 0;
		while (done < RANDOM_CMDS) begin
			steady = (done >= 300 && done < 420);
			n = mirror.entries.size();
			if ($urandom_range(99) < 3) begin
				send_command(OP_UNUSED, POS_W'($urandom_range(127, 0)),
					VAL_W'($urandom_range(255, 0)));
			end else begin
				if ($urandom_range(99) < weights[(done / PHASE_LEN) % 7])
					op = OP_INSERT;
				else if ($urandom_range(1, 0) == 0)
					op = OP_DELETE;
				else
					op = OP_READ;
				send_command(op, pick_position(op == OP_INSERT ? n + 1 : n),
					VAL_W'($urandom_range(255, 0)));
				done++;
			end
		end
		steady = 1'b0;
	endtask

	initial begin : stimulus
		arst_n         = 1'b0;
		steady         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.operation  = OP_INSERT;
		cmd.position   = '0;
		cmd.item_value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		cmd.valid <= 1'b0;
		while (mirror.replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d commands applied (%0d with the unused code), %0d replies checked,",
			mirror.commands_seen, mirror.unused_seen, mirror.replies_seen);
		$display("peak fill %0d of %0d; status ok %0d, range %0d, empty %0d, full %0d",
			mirror.peak_fill, PLE_CAPACITY, mirror.status_tally[ST_OK],
			mirror.status_tally[ST_RANGE], mirror.status_tally[ST_EMPTY],
			mirror.status_tally[ST_FULL]);
		if (mirror.mismatches == 0 && mirror.replies_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Reply side: checks each accepted beat, then decides ready for the next
	// edge. Twice in the run it holds ready low for a long stretch while the
	// sender keeps offering, so the engine sits on a reply and stops taking
	// commands.
	initial begin : reply_side
		int  hold_left;
		bit  took;
		hold_left = 0;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			took = rsp.valid && rsp.ready;
			if (took) begin
				mirror.check_reply(rsp.read_value, rsp.status, rsp.entry_count,
					rsp.is_empty);
				if (mirror.replies_seen == 200 || mirror.replies_seen == 600)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Watchdog: any beat on either channel restarts the count.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("no beat for %0d cycles", WATCHDOG_MAX);
				$display("simulation failed");
				$finish;
			end
		end
	end

endmodule
